/* hdl/epra_pkg.sv */
`timescale 1ns / 1ps

package epra_pkg;

    // Field widths of the words on both channels.
    localparam int FUNC_W     = 2;
    localparam int STAMP_W    = 16;
    localparam int SAMPLE_W   = 13;
    localparam int PERIOD_W   = 8;
    localparam int WAIT_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Largest distance a 16-bit tick count can give: 65535 * 5 / 58.
    localparam int MAX_SAMPLE = 5649;

    // Tick count times five fits in 19 bits.
    localparam int TICKS5_W = STAMP_W + 3;

    // Division by 58 as a multiplication by ceil(2^25 / 58). The error term
    // (18) times the largest dividend stays below 2^25, so the quotient is exact.
    localparam int                DIV58_SHIFT = 25;
    localparam int                DIV58_W     = 20;
    localparam logic [DIV58_W-1:0] DIV58_RECIP = 20'd578525;

    // Item codes.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_CAPTURE  = 2'd0,
        FUNC_TRIGGER  = 2'd1,
        FUNC_OVERFLOW = 2'd2
    } func_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SNAPSHOT_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_WAIT   = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd25;
    localparam logic [WAIT_W-1:0]   WAIT_RESET   = 2'd2;

    // Control for one cell of the sample window.
    typedef struct packed {
        logic load;
        logic prime;
    } cell_ctl_t;

endpackage

/* hdl/epra_item_if.sv */
`timescale 1ns / 1ps

interface epra_item_if;
    logic                         valid;
    logic                         ready;
    logic [epra_pkg::FUNC_W-1:0]  func;
    logic [epra_pkg::STAMP_W-1:0] capture_time;

    modport source (output valid, func, capture_time, input ready);
    modport sink   (input valid, func, capture_time, output ready);
endinterface

/* hdl/epra_result_if.sv */
`timescale 1ns / 1ps

interface epra_result_if;
    logic                          valid;
    logic                          ready;
    logic                          trigger_granted;
    logic                          distance_valid;
    logic [epra_pkg::SAMPLE_W-1:0] average_distance;
    logic [epra_pkg::SAMPLE_W-1:0] snapshot_distance;
    logic                          reading_allowed;

    modport source (output valid, trigger_granted, distance_valid, average_distance,
                    snapshot_distance, reading_allowed, input ready);
    modport sink   (input valid, trigger_granted, distance_valid, average_distance,
                    snapshot_distance, reading_allowed, output ready);
endinterface

/* hdl/epra_cell.sv */
`timescale 1ns / 1ps

module epra_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  epra_pkg::cell_ctl_t           ctl,
    input  logic [epra_pkg::SAMPLE_W-1:0] prime_value,
    input  logic [epra_pkg::SAMPLE_W-1:0] shift_in,
    output logic [epra_pkg::SAMPLE_W-1:0] value
);

    logic [epra_pkg::SAMPLE_W-1:0] value_reg;
    logic [epra_pkg::SAMPLE_W-1:0] value_next;

    // A primed window takes the new sample in every cell at once.
    always_comb
    begin
        value_next = value_reg;
        if (ctl.load)
        begin
            value_next = ctl.prime ? prime_value : shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

/* hdl/epra_window.sv */
`timescale 1ns / 1ps

module epra_window #(
    parameter int WINDOW  = 5,
    parameter int TOTAL_W = 15
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [epra_pkg::SAMPLE_W-1:0] sample,
    output logic [TOTAL_W-1:0]            total
);

    localparam int POS_W = $clog2(WINDOW);

    logic [TOTAL_W-1:0]            total_reg;
    logic [TOTAL_W-1:0]            total_next;
    logic [POS_W-1:0]              pos_reg;
    logic [POS_W-1:0]              pos_next;
    logic                          prime;
    epra_pkg::cell_ctl_t           ctl;
    logic [epra_pkg::SAMPLE_W-1:0] cell_value [WINDOW];
    logic [TOTAL_W-1:0]            sample_ext;
    logic [TOTAL_W-1:0]            oldest_ext;

    // An empty window at position zero is filled with the first sample.
    assign prime      = (total_reg == '0) && (pos_reg == '0);
    assign ctl.load   = load;
    assign ctl.prime  = prime;
    assign sample_ext = TOTAL_W'(sample);
    assign oldest_ext = TOTAL_W'(cell_value[WINDOW-1]);

    // The last cell holds the oldest sample, the one that leaves the window.
    genvar k;
    generate
        for (k = 0; k < WINDOW; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                epra_cell u_cell (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .ctl         (ctl),
                    .prime_value (sample),
                    .shift_in    (sample),
                    .value       (cell_value[k])
                );
            end
            else
            begin : g_body
                epra_cell u_cell (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .ctl         (ctl),
                    .prime_value (sample),
                    .shift_in    (cell_value[k-1]),
                    .value       (cell_value[k])
                );
            end
        end
    endgenerate

    always_comb
    begin
        total_next = total_reg;
        pos_next   = pos_reg;
        if (load)
        begin
            if (prime)
            begin
                total_next = TOTAL_W'(sample_ext * TOTAL_W'(WINDOW));
            end
            else
            begin
                total_next = total_reg - oldest_ext + sample_ext;
            end
            pos_next = (pos_reg == POS_W'(WINDOW - 1)) ? '0 : pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            total_reg <= total_next;
            pos_reg   <= pos_next;
        end
    end

    assign total = total_reg;

endmodule

/* hdl/echo_pulse_range_averager_core.sv */
`timescale 1ns / 1ps
// A word's result appears on the result channel after it has passed stages A, B and C.
// Throughput: one word per cycle; the three stages (distance, window total, average)
// each hold one word and a stalled result lets bubbles ahead of it close up.
// Reset: rst_n is asynchronous and active low; it empties the pipeline, clears the
// window cells, the total and the counters, and loads the register defaults.

module echo_pulse_range_averager_core #(
    parameter int WINDOW = 5
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [epra_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [epra_pkg::CFG_DATA_W-1:0] cfg_data,
    epra_item_if.sink                       item,
    epra_result_if.source                   result
);

    // The window total must hold WINDOW copies of the largest distance.
    localparam int TOTAL_W = $clog2(epra_pkg::MAX_SAMPLE * WINDOW + 1);
    // The average is total / WINDOW, done as a multiplication by a rounded-up
    // reciprocal. With WINDOW at most 16 the error term times any total stays
    // below 2^AVG_SHIFT, so the quotient is exact.
    localparam int AVG_SHIFT = TOTAL_W + 4;
    localparam int AVG_RECIP = ((1 << AVG_SHIFT) + WINDOW - 1) / WINDOW;
    localparam int AVG_PROD_W = TOTAL_W + AVG_SHIFT;
    // Width of the tick-to-distance product.
    localparam int DIST_PROD_W = epra_pkg::TICKS5_W + epra_pkg::DIV58_W;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [epra_pkg::PERIOD_W-1:0] period_reg;
    logic [epra_pkg::WAIT_W-1:0]   wait_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= epra_pkg::PERIOD_RESET;
            wait_reg   <= epra_pkg::WAIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                epra_pkg::CFG_SNAPSHOT_PERIOD:
                begin
                    period_reg <= cfg_data[epra_pkg::PERIOD_W-1:0];
                end
                epra_pkg::CFG_OVERFLOW_WAIT:
                begin
                    wait_reg <= cfg_data[epra_pkg::WAIT_W-1:0];
                end
                default:
                begin
                    period_reg <= period_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage moves on when the stage after it is
    // empty or moving on itself, so a held result does not block words that
    // still have room ahead of them.
    // ------------------------------------------------------------------
    logic a_valid_reg;
    logic b_valid_reg;
    logic c_valid_reg;
    logic adv_a;
    logic adv_b;
    logic adv_c;

    assign adv_c      = b_valid_reg && (!c_valid_reg || result.ready);
    assign adv_b      = a_valid_reg && (!b_valid_reg || adv_c);
    assign item.ready = !a_valid_reg || adv_b;
    assign adv_a      = item.valid && item.ready;

    // ------------------------------------------------------------------
    // Stage A: edge pairing, tick-to-distance conversion and the trigger
    // handshake with the overflow counter. All of this state is consulted
    // and updated by one word at a time here.
    // ------------------------------------------------------------------
    logic                           expect_rising_reg;
    logic                           expect_rising_next;
    logic [epra_pkg::STAMP_W-1:0]   start_stamp_reg;
    logic [epra_pkg::STAMP_W-1:0]   start_stamp_next;
    logic                           allowed_reg;
    logic                           allowed_next;
    logic                           armed_reg;
    logic                           armed_next;
    logic [epra_pkg::WAIT_W-1:0]    ovf_count_reg;
    logic [epra_pkg::WAIT_W-1:0]    ovf_count_next;

    logic [epra_pkg::STAMP_W-1:0]   ticks;
    logic [epra_pkg::TICKS5_W-1:0]  ticks5;
    logic [DIST_PROD_W-1:0]         dist_prod;
    logic [epra_pkg::SAMPLE_W-1:0]  distance;
    logic                           granted;
    logic                           sample_valid;

    logic                           a_granted_reg;
    logic                           a_sample_valid_reg;
    logic                           a_allowed_reg;
    logic [epra_pkg::SAMPLE_W-1:0]  a_sample_reg;

    // The subtraction wraps modulo 2^16, which covers a timer rollover.
    assign ticks     = item.capture_time - start_stamp_reg;
    assign ticks5    = epra_pkg::TICKS5_W'({ticks, 2'b00}) + epra_pkg::TICKS5_W'(ticks);
    assign dist_prod = DIST_PROD_W'(ticks5) * DIST_PROD_W'(epra_pkg::DIV58_RECIP);
    assign distance  = dist_prod[epra_pkg::DIV58_SHIFT +: epra_pkg::SAMPLE_W];

    always_comb
    begin
        expect_rising_next = expect_rising_reg;
        start_stamp_next   = start_stamp_reg;
        allowed_next       = allowed_reg;
        armed_next         = armed_reg;
        ovf_count_next     = ovf_count_reg;
        granted            = 1'b0;
        sample_valid       = 1'b0;
        case (epra_pkg::func_t'(item.func))
            epra_pkg::FUNC_CAPTURE:
            begin
                if (expect_rising_reg)
                begin
                    start_stamp_next   = item.capture_time;
                    expect_rising_next = 1'b0;
                end
                else
                begin
                    expect_rising_next = 1'b1;
                    sample_valid       = 1'b1;
                end
            end
            epra_pkg::FUNC_TRIGGER:
            begin
                // A request always closes the gate, even when it is refused.
                if (allowed_reg)
                begin
                    granted    = 1'b1;
                    armed_next = 1'b1;
                end
                allowed_next = 1'b0;
            end
            epra_pkg::FUNC_OVERFLOW:
            begin
                // Ticks only count after a grant has armed the counter.
                if (armed_reg)
                begin
                    if (ovf_count_reg >= wait_reg)
                    begin
                        armed_next     = 1'b0;
                        allowed_next   = 1'b1;
                        ovf_count_next = '0;
                    end
                    else
                    begin
                        ovf_count_next = ovf_count_reg + epra_pkg::WAIT_W'(1);
                    end
                end
            end
            default:
            begin
                // An unknown code passes through and changes nothing.
                granted = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_rising_reg <= 1'b1;
            start_stamp_reg   <= '0;
            allowed_reg       <= 1'b1;
            armed_reg         <= 1'b0;
            ovf_count_reg     <= '0;
            a_valid_reg       <= 1'b0;
        end
        else
        begin
            if (adv_a)
            begin
                expect_rising_reg <= expect_rising_next;
                start_stamp_reg   <= start_stamp_next;
                allowed_reg       <= allowed_next;
                armed_reg         <= armed_next;
                ovf_count_reg     <= ovf_count_next;
                a_valid_reg       <= 1'b1;
            end
            else if (adv_b)
            begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            a_granted_reg      <= granted;
            a_sample_valid_reg <= sample_valid;
            a_allowed_reg      <= allowed_next;
            a_sample_reg       <= distance;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: the window of cells and its running total. A sample enters
    // the chain as its word moves from stage A into stage B.
    // ------------------------------------------------------------------
    logic [TOTAL_W-1:0] window_total;
    logic               b_granted_reg;
    logic               b_sample_valid_reg;
    logic               b_allowed_reg;

    epra_window #(
        .WINDOW  (WINDOW),
        .TOTAL_W (TOTAL_W)
    ) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (adv_b && a_sample_valid_reg),
        .sample (a_sample_reg),
        .total  (window_total)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (adv_b)
        begin
            b_valid_reg <= 1'b1;
        end
        else if (adv_c)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_b)
        begin
            b_granted_reg      <= a_granted_reg;
            b_sample_valid_reg <= a_sample_valid_reg;
            b_allowed_reg      <= a_allowed_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: average, snapshot and the output register. The average and
    // snapshot registers are both state and result payload; they change only
    // when a sample word moves in, so a held result stays stable.
    // ------------------------------------------------------------------
    logic [AVG_PROD_W-1:0]         avg_prod;
    logic [epra_pkg::SAMPLE_W-1:0] avg_new;
    logic [epra_pkg::SAMPLE_W-1:0] average_reg;
    logic [epra_pkg::SAMPLE_W-1:0] average_next;
    logic [epra_pkg::SAMPLE_W-1:0] snapshot_reg;
    logic [epra_pkg::SAMPLE_W-1:0] snapshot_next;
    logic [epra_pkg::PERIOD_W-1:0] count_reg;
    logic [epra_pkg::PERIOD_W-1:0] count_next;
    logic                          c_granted_reg;
    logic                          c_sample_valid_reg;
    logic                          c_allowed_reg;

    assign avg_prod = AVG_PROD_W'(window_total) * AVG_PROD_W'(AVG_RECIP);
    assign avg_new  = avg_prod[AVG_SHIFT +: epra_pkg::SAMPLE_W];

    always_comb
    begin
        average_next  = average_reg;
        snapshot_next = snapshot_reg;
        count_next    = count_reg;
        if (adv_c && b_sample_valid_reg)
        begin
            average_next = avg_new;
            // The snapshot refreshes on the sample that finds the count at
            // or above the period, which makes the interval period + 1.
            if (count_reg >= period_reg)
            begin
                snapshot_next = avg_new;
                count_next    = '0;
            end
            else
            begin
                count_next = count_reg + epra_pkg::PERIOD_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            average_reg  <= '0;
            snapshot_reg <= '0;
            count_reg    <= '0;
            c_valid_reg  <= 1'b0;
        end
        else
        begin
            average_reg  <= average_next;
            snapshot_reg <= snapshot_next;
            count_reg    <= count_next;
            if (adv_c)
            begin
                c_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                c_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_c)
        begin
            c_granted_reg      <= b_granted_reg;
            c_sample_valid_reg <= b_sample_valid_reg;
            c_allowed_reg      <= b_allowed_reg;
        end
    end

    assign result.valid             = c_valid_reg;
    assign result.trigger_granted   = c_granted_reg;
    assign result.distance_valid    = c_sample_valid_reg;
    assign result.average_distance  = average_reg;
    assign result.snapshot_distance = snapshot_reg;
    assign result.reading_allowed   = c_allowed_reg;

endmodule
